[sv/lsse_pkg.sv]
// Shared types, constants and the symbol encoding function for the LED strip symbol encoder.
`default_nettype none
package lsse_pkg;

  localparam int MAX_SLOTS     = 4;
  localparam int NUM_SLOT_REGS = 4;
  localparam int CNT_W         = $clog2(MAX_SLOTS + 1);
  localparam int SEL_W         = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int TRAIL_W       = 6;
  localparam int TRAIL_MAX     = 59;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  localparam logic [2:0] REG_COLOR_COUNT = 3'd0;
  localparam logic [2:0] REG_SLOT0       = 3'd1;
  localparam logic [2:0] REG_SLOT1       = 3'd2;
  localparam logic [2:0] REG_SLOT2       = 3'd3;
  localparam logic [2:0] REG_SLOT3       = 3'd4;
  localparam logic [2:0] REG_TRAIL       = 3'd5;
  localparam logic [2:0] REG_INVERT      = 3'd6;

  localparam logic [1:0] COLOR_WHITE = 2'd0;
  localparam logic [1:0] COLOR_RED   = 2'd1;
  localparam logic [1:0] COLOR_GREEN = 2'd2;
  localparam logic [1:0] COLOR_BLUE  = 2'd3;

  localparam logic [3:0] SYM_BIT1     = 4'hE;
  localparam logic [3:0] SYM_BIT0     = 4'h8;
  localparam logic [3:0] SYM_BIT1_INV = 4'h1;
  localparam logic [3:0] SYM_BIT0_INV = 4'h7;
  localparam int         HALF_W       = 16;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [31:0] serial_word;
    logic        is_reset_word;
    logic        last_of_run;
  } word_t;

  typedef struct packed {
    logic [2:0]                    color_count;
    logic [NUM_SLOT_REGS-1:0][1:0] slot_color;
    logic [TRAIL_W-1:0]            trailing_reset_words;
    logic                          invert_output;
  } cfg_t;

  function automatic logic [31:0] encode_byte(input logic [7:0] v, input logic inv);
    logic [31:0] w;
    logic [3:0]  one;
    logic [3:0]  zero;
    one  = inv ? SYM_BIT1_INV : SYM_BIT1;
    zero = inv ? SYM_BIT0_INV : SYM_BIT0;
    for (int b = 0; b < 8; b++) begin
      w[b*4 +: 4] = v[b] ? one : zero;
    end
    return {w[HALF_W-1:0], w[31:HALF_W]};
  endfunction

endpackage
`default_nettype wire

[sv/lsse_regs.sv]
// Configuration register file behind the APB-style port.
`default_nettype none
module lsse_regs
  import lsse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_count          <= 3'd3;
      cfg.slot_color[0]        <= COLOR_GREEN;
      cfg.slot_color[1]        <= COLOR_RED;
      cfg.slot_color[2]        <= COLOR_BLUE;
      cfg.slot_color[3]        <= COLOR_WHITE;
      cfg.trailing_reset_words <= TRAIL_W'(14);
      cfg.invert_output        <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_COLOR_COUNT: cfg.color_count          <= pwdata[2:0];
        REG_SLOT0:       cfg.slot_color[0]        <= pwdata[1:0];
        REG_SLOT1:       cfg.slot_color[1]        <= pwdata[1:0];
        REG_SLOT2:       cfg.slot_color[2]        <= pwdata[1:0];
        REG_SLOT3:       cfg.slot_color[3]        <= pwdata[1:0];
        REG_TRAIL:       cfg.trailing_reset_words <= pwdata[TRAIL_W-1:0];
        REG_INVERT:      cfg.invert_output        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COLOR_COUNT: prdata = DATA_W'(cfg.color_count);
      REG_SLOT0:       prdata = DATA_W'(cfg.slot_color[0]);
      REG_SLOT1:       prdata = DATA_W'(cfg.slot_color[1]);
      REG_SLOT2:       prdata = DATA_W'(cfg.slot_color[2]);
      REG_SLOT3:       prdata = DATA_W'(cfg.slot_color[3]);
      REG_TRAIL:       prdata = DATA_W'(cfg.trailing_reset_words);
      REG_INVERT:      prdata = DATA_W'(cfg.invert_output);
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[sv/lsse_lane.sv]
// One color slot lane: picks the slot's channel and holds its encoded word.
`default_nettype none
module lsse_lane
  import lsse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        load,
  input  wire pixel_t      pixel,
  input  wire logic [1:0]  color,
  input  wire logic        invert,
  output logic      [31:0] lane_word
);

  logic [7:0] level;

  always_comb begin
    case (color)
      COLOR_RED:   level = pixel.red;
      COLOR_GREEN: level = pixel.green;
      COLOR_BLUE:  level = pixel.blue;
      default:     level = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lane_word <= encode_byte(level, invert);
    end
  end

endmodule
`default_nettype wire

[sv/lsse_seq.sv]
// Word sequencer: leading reset word, lane words in slot order, trailing reset words.
`default_nettype none
module lsse_seq
  import lsse_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cfg_t                        cfg,
  input  wire logic                        pixel_valid,
  input  wire logic                        pixel_last,
  output logic                             pixel_ready,
  output logic                             load,
  input  wire logic [MAX_SLOTS-1:0][31:0]  lane_word,
  output logic                             word_valid,
  input  wire logic                        word_ready,
  output word_t                            word
);

  logic               busy;
  logic               lead_pend;
  logic [CNT_W-1:0]   slot_idx;
  logic [CNT_W-1:0]   slot_total;
  logic [TRAIL_W-1:0] trail_left;
  logic               inside_frame;

  logic [CNT_W-1:0]   slots_sat;
  logic [TRAIL_W-1:0] trail_sat;
  logic [TRAIL_W-1:0] trail_load;
  logic [31:0]        rword;
  logic               adv;
  logic               in_slots;
  logic               emit_last;
  word_t              emit;

  assign rword     = {32{cfg.invert_output}};
  assign slots_sat = (cfg.color_count > 3'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                         : CNT_W'(cfg.color_count);
  assign trail_sat = (cfg.trailing_reset_words > TRAIL_W'(TRAIL_MAX)) ? TRAIL_W'(TRAIL_MAX)
                                                                     : cfg.trailing_reset_words;
  assign trail_load = pixel_last ? trail_sat : '0;

  assign in_slots = (slot_idx < slot_total);
  assign adv      = busy && (!word_valid || word_ready);

  always_comb begin
    emit = '0;
    if (lead_pend) begin
      emit.serial_word   = rword;
      emit.is_reset_word = 1'b1;
      emit_last          = (slot_total == '0) && (trail_left == '0);
    end else if (in_slots) begin
      emit.serial_word   = lane_word[slot_idx[SEL_W-1:0]];
      emit.is_reset_word = 1'b0;
      emit_last          = (slot_idx + CNT_W'(1) == slot_total) && (trail_left == '0);
    end else begin
      emit.serial_word   = rword;
      emit.is_reset_word = 1'b1;
      emit_last          = (trail_left == TRAIL_W'(1));
    end
    emit.last_of_run = emit_last;
  end

  assign pixel_ready = !busy || (adv && emit_last);
  assign load        = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      lead_pend    <= 1'b0;
      slot_idx     <= '0;
      slot_total   <= '0;
      trail_left   <= '0;
      inside_frame <= 1'b0;
    end else if (load) begin
      busy         <= !inside_frame || (slots_sat != '0) || (trail_load != '0);
      lead_pend    <= !inside_frame;
      slot_idx     <= '0;
      slot_total   <= slots_sat;
      trail_left   <= trail_load;
      inside_frame <= !pixel_last;
    end else if (adv) begin
      if (emit_last) begin
        busy <= 1'b0;
      end
      if (lead_pend) begin
        lead_pend <= 1'b0;
      end else if (in_slots) begin
        slot_idx <= slot_idx + CNT_W'(1);
      end else begin
        trail_left <= trail_left - TRAIL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (adv) begin
      word_valid <= 1'b1;
    end else if (word_ready) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word <= emit;
    end
  end

endmodule
`default_nettype wire

[sv/led_strip_symbol_encoder.sv]
// Top level of the LED strip symbol encoder: registers, slot lanes and word sequencer.
//
//   channel   direction  handshake                      word
//   pixel     in         pixel_valid / pixel_ready      pixel_t (red, green, blue, last_pixel)
//   word      out        word_valid / word_ready        word_t (serial_word, is_reset_word,
//                                                              last_of_run)
//   apb       in/out     psel, penable, pwrite, pready  32-bit registers at 4*index
//
// One output word per cycle, unless the output stalls, from a registered output
// stage; a pixel yields (leading reset word) + color slots + (trailing reset
// words), so four or fewer words in mid-frame. All slot lanes encode in the cycle
// the pixel is taken.
// The next pixel is taken in the cycle the previous one's last word issues.
// Reset is synchronous; output stalls hold the word and the sequencer.
`default_nettype none
module led_strip_symbol_encoder
  import lsse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pixel_valid,
  output logic                   pixel_ready,
  input  wire pixel_t            pixel,
  output logic                   word_valid,
  input  wire logic              word_ready,
  output word_t                  word,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t                       cfg;
  logic                       load;
  logic [MAX_SLOTS-1:0][31:0] lane_word;

  lsse_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_lane
    lsse_lane u_lane (
      .clk       (clk),
      .load      (load),
      .pixel     (pixel),
      .color     (cfg.slot_color[i]),
      .invert    (cfg.invert_output),
      .lane_word (lane_word[i])
    );
  end

  lsse_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_last  (pixel.last_pixel),
    .pixel_ready (pixel_ready),
    .load        (load),
    .lane_word   (lane_word),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .word        (word)
  );

endmodule
`default_nettype wire
